// ===== rtl/dsc_pkg.sv =====
// shared types, codes and constants for the display scan capture block
`timescale 1ns / 1ps

package dsc_pkg;

  localparam int unsigned SCAN_POS = 14;

  localparam logic [13:0] REAL_POS_MASK = 14'h0FFF;
  localparam logic [7:0]  RUNNING_CODE  = 8'h6F;
  localparam logic [3:0]  LAST_SAMPLE   = 4'd13;
  localparam logic [3:0]  LAST_POS      = 4'd13;
  localparam logic [3:0]  SIGN_POS      = 4'd0;
  localparam logic [3:0]  RUN_POS       = 4'd12;

  // register reset values
  localparam logic [7:0]  SEG_MASK_RST     = 8'd255;
  localparam logic        INCL_VIRT_RST    = 1'b0;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;
  localparam logic [7:0]  SIGN_MASK_RST    = 8'd64;

  // configuration register indexes
  localparam logic [1:0] REG_SEG_MASK   = 2'd0;
  localparam logic [1:0] REG_INCL_VIRT  = 2'd1;
  localparam logic [1:0] REG_MIN_INTVL  = 2'd2;
  localparam logic [1:0] REG_SIGN_MASK  = 2'd3;

  // input command codes
  localparam logic [1:0] CMD_GRID  = 2'd0;
  localparam logic [1:0] CMD_TIMED = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_BLANK = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SAMPLE,
    S_END,
    S_COPY,
    S_RDDATA,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic mark_seen;
    logic start_cycle;
    logic do_sample;
    logic end_cycle;
    logic copy_step;
    logic rd_issue;
    logic rd_capture;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       seen;
    logic       short_intvl;
    logic       active;
    logic       last_sample;
    logic       end_store;
    logic       end_dark;
    logic       blank_zero;
    logic       copy_last;
    logic       out_free;
  } ctrl_sts_t;

  // scan order 8,7,6,5,4,3,2,1,0,11,10,9,12,13
  function automatic logic [3:0] scan_pos(input logic [3:0] idx);
    logic [3:0] p;
    case (idx)
      4'd0:    p = 4'd8;
      4'd1:    p = 4'd7;
      4'd2:    p = 4'd6;
      4'd3:    p = 4'd5;
      4'd4:    p = 4'd4;
      4'd5:    p = 4'd3;
      4'd6:    p = 4'd2;
      4'd7:    p = 4'd1;
      4'd8:    p = 4'd0;
      4'd9:    p = 4'd11;
      4'd10:   p = 4'd10;
      4'd11:   p = 4'd9;
      4'd12:   p = 4'd12;
      4'd13:   p = 4'd13;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/dsc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 224
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/dsc_ctrl.sv =====
// sequencing state machine of the display scan capture block
`timescale 1ns / 1ps

module dsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsc_pkg::ctrl_sts_t sts,
  output dsc_pkg::ctrl_cmd_t cmd
);
  import dsc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sts.command)
          CMD_GRID: begin
            if (sts.seen && !sts.short_intvl) state_nxt = S_SAMPLE;
            else state_nxt = S_IDLE;
          end
          CMD_TIMED: begin
            if (sts.active) state_nxt = S_SAMPLE;
            else state_nxt = S_IDLE;
          end
          CMD_READ: state_nxt = S_RDDATA;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_SAMPLE: begin
        if (sts.last_sample) state_nxt = S_END;
        else state_nxt = S_IDLE;
      end
      S_END: begin
        if (sts.end_store) state_nxt = S_COPY;
        else if (sts.end_dark && sts.blank_zero) state_nxt = S_EMIT;
        else state_nxt = S_IDLE;
      end
      S_COPY: begin
        if (sts.copy_last) state_nxt = S_EMIT;
      end
      S_RDDATA: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_EXEC: begin
        case (sts.command)
          CMD_GRID: begin
            cmd.mark_seen   = !sts.seen;
            cmd.start_cycle = sts.seen && !sts.short_intvl;
          end
          CMD_READ: cmd.rd_issue = 1'b1;
          default:  cmd = '0;
        endcase
      end
      S_SAMPLE: cmd.do_sample  = 1'b1;
      S_END:    cmd.end_cycle  = 1'b1;
      S_COPY:   cmd.copy_step  = 1'b1;
      S_RDDATA: cmd.rd_capture = 1'b1;
      S_EMIT:   cmd.load_out   = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/dsc_datapath.sv =====
// scan store, masks, counters, line ring and result registers
`timescale 1ns / 1ps

module dsc_datapath #(
  parameter int RING_LINES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_segments,
  input  logic [15:0]        in_interval_us,
  input  logic [3:0]         in_read_line,
  input  logic [3:0]         in_read_pos,
  input  dsc_pkg::ctrl_cmd_t cmd,
  output dsc_pkg::ctrl_sts_t sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_line_slot,
  output logic               out_exec_flag,
  output logic [15:0]        out_blank_cycles,
  output logic [7:0]         out_read_data
);
  import dsc_pkg::*;

  localparam int DEPTH = RING_LINES * SCAN_POS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(RING_LINES);

  // configuration
  logic [7:0]  seg_mask_r;
  logic        incl_virt_r;
  logic [15:0] min_intvl_r;
  logic [7:0]  sign_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_mask_r  <= SEG_MASK_RST;
      incl_virt_r <= INCL_VIRT_RST;
      min_intvl_r <= MIN_INTERVAL_RST;
      sign_mask_r <= SIGN_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_MASK:  seg_mask_r  <= cfg_data[7:0];
        REG_INCL_VIRT: incl_virt_r <= cfg_data[0];
        REG_MIN_INTVL: min_intvl_r <= cfg_data;
        REG_SIGN_MASK: sign_mask_r <= cfg_data[7:0];
        default:       seg_mask_r  <= seg_mask_r;
      endcase
    end
  end

  // latched item
  logic [1:0]  cmd_code_r;
  logic [7:0]  seg_r;
  logic [15:0] intvl_r;
  logic [3:0]  rline_r;
  logic [3:0]  rpos_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_code_r <= in_command;
      seg_r      <= in_segments;
      intvl_r    <= in_interval_us;
      rline_r    <= in_read_line;
      rpos_r     <= in_read_pos;
    end
  end

  // scan state
  logic [7:0]  scan_r [SCAN_POS];
  logic [13:0] changed_r, lit_r;
  logic [3:0]  count_r;
  logic        active_r, seen_r, running_r;
  logic [15:0] blank_r;
  logic [SW-1:0] wslot_r;
  logic [3:0]  copy_k_r;

  logic [3:0]  pos;
  logic [3:0]  scan_idx;
  logic [7:0]  scan_rd;
  logic [7:0]  seg_m;
  logic [13:0] vmask, chg_v, lit_v;
  logic        end_store, end_dark;
  logic [7:0]  copy_data;

  assign pos       = scan_pos(count_r);
  assign scan_idx  = cmd.copy_step ? copy_k_r : pos;
  assign scan_rd   = scan_r[scan_idx];
  assign seg_m     = seg_r & seg_mask_r;
  assign vmask     = incl_virt_r ? '1 : REAL_POS_MASK;
  assign chg_v     = changed_r & vmask;
  assign lit_v     = lit_r & vmask;
  assign end_store = (chg_v != '0) && (lit_v != '0);
  assign end_dark  = (lit_v == '0);
  assign copy_data = (copy_k_r == SIGN_POS) ? (scan_rd & sign_mask_r) : scan_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCAN_POS; i++) scan_r[i] <= '0;
      changed_r <= '0;
      lit_r     <= '0;
      count_r   <= '0;
      active_r  <= 1'b0;
      seen_r    <= 1'b0;
      running_r <= 1'b0;
      blank_r   <= '0;
      wslot_r   <= '0;
      copy_k_r  <= '0;
    end else begin
      if (cmd.mark_seen) seen_r <= 1'b1;
      if (cmd.start_cycle) begin
        count_r   <= '0;
        changed_r <= '0;
        lit_r     <= '0;
        active_r  <= 1'b1;
      end
      if (cmd.do_sample) begin
        if (seg_m != '0) lit_r[pos] <= 1'b1;
        if (scan_rd != seg_m) changed_r[pos] <= 1'b1;
        scan_r[pos] <= seg_m;
        count_r     <= count_r + 4'd1;
      end
      if (cmd.end_cycle) begin
        active_r  <= 1'b0;
        changed_r <= chg_v;
        lit_r     <= lit_v;
        if (end_store) begin
          running_r <= (scan_r[RUN_POS] == RUNNING_CODE);
          blank_r   <= '0;
          copy_k_r  <= '0;
        end else if (end_dark) begin
          blank_r <= blank_r + 16'd1;
        end
      end
      if (cmd.copy_step) begin
        copy_k_r <= copy_k_r + 4'd1;
        if (copy_k_r == SIGN_POS) scan_r[SIGN_POS] <= copy_data;
        if (copy_k_r == LAST_POS) begin
          wslot_r <= (wslot_r == SW'(RING_LINES - 1)) ? '0 : wslot_r + SW'(1);
        end
      end
    end
  end

  // read slot wraps modulo the ring size: small constant table
  logic [SW-1:0] rslot_tbl [16];
  always_comb begin
    for (int i = 0; i < 16; i++) rslot_tbl[i] = SW'(i % RING_LINES);
  end

  logic [SW-1:0] rslot;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    ram_rdata;

  assign rslot = rslot_tbl[rline_r];
  // slot * 14 = slot * 16 - slot * 2
  assign waddr = (AW'(wslot_r) << 4) - (AW'(wslot_r) << 1) + AW'(copy_k_r);
  assign raddr = (AW'(rslot) << 4) - (AW'(rslot) << 1) + AW'(rpos_r);

  dsc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.copy_step),
    .waddr (waddr),
    .wdata (copy_data),
    .re    (cmd.rd_issue && (rpos_r <= LAST_POS)),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // pending result
  logic [1:0]  pend_kind_r;
  logic [3:0]  pend_slot_r;
  logic        pend_flag_r;
  logic [15:0] pend_blank_r;
  logic [7:0]  pend_data_r;

  always_ff @(posedge clk) begin
    if (cmd.end_cycle) begin
      pend_data_r <= '0;
      if (end_store) begin
        pend_kind_r  <= KIND_LINE;
        pend_slot_r  <= 4'(wslot_r);
        pend_flag_r  <= (scan_r[RUN_POS] == RUNNING_CODE);
        pend_blank_r <= blank_r;
      end else begin
        pend_kind_r  <= KIND_BLANK;
        pend_slot_r  <= '0;
        pend_flag_r  <= running_r;
        pend_blank_r <= '0;
      end
    end
    if (cmd.rd_capture) begin
      pend_kind_r  <= KIND_READ;
      pend_slot_r  <= '0;
      pend_flag_r  <= 1'b0;
      pend_blank_r <= '0;
      pend_data_r  <= (rpos_r <= LAST_POS) ? ram_rdata : '0;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind         <= pend_kind_r;
      out_line_slot    <= pend_slot_r;
      out_exec_flag    <= pend_flag_r;
      out_blank_cycles <= pend_blank_r;
      out_read_data    <= pend_data_r;
    end
  end

  assign out_valid = out_valid_r;

  // status
  always_comb begin
    sts             = '0;
    sts.command     = cmd_code_r;
    sts.seen        = seen_r;
    sts.short_intvl = (intvl_r < min_intvl_r);
    sts.active      = active_r;
    sts.last_sample = (count_r == LAST_SAMPLE);
    sts.end_store   = end_store;
    sts.end_dark    = end_dark;
    sts.blank_zero  = (blank_r == '0);
    sts.copy_last   = (copy_k_r == LAST_POS);
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

// ===== rtl/display_scan_capture_core.sv =====
// top level of the display scan capture block
`timescale 1ns / 1ps

// Captures a multiplexed 14-position display scan and reports changed lines.
// in_ channel: one beat per sample or command. in_tuser carries the command
// (grid start, timed sample, read a stored byte); in_tdata carries the raw
// segments, the grid-start interval and the ring slot/position for reads.
// out_ channel: at most one beat per input beat. out_tuser is the kind
// (line stored, display went blank, read data); out_tdata carries the slot,
// running flag, blank-cycle count and read byte.
// cfg_ port: one register written per cycle with cfg_we high, only while idle;
// the user must keep to that, the block does not enforce it. Sequencing: one
// beat at a time through the sequencer. A timed sample passes exec and sample;
// a read passes exec, read data and emit plus any output stall; the sample that
// closes a scan and stores a line passes sample, end, the one-byte-a-cycle copy
// into the ring memory write port, and emit. Reset clears all scan state and
// restores register defaults; the ring memory is not cleared. The output
// register holds a result while out_tready is low; a following beat is still
// taken and worked on until it needs that register itself.

module display_scan_capture_core #(
  parameter int RING_LINES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // segments[7:0], interval_us[23:8],
                                  // read_line[27:24], read_pos[31:28]
  input  logic [1:0]  in_tuser,   // command[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // line_slot[3:0], exec_flag[4],
                                  // blank_cycles[20:5], read_data[28:21], zero
  output logic [1:0]  out_tuser   // kind[1:0]
);
  import dsc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic [3:0]  line_slot;
  logic        exec_flag;
  logic [15:0] blank_cycles;
  logic [7:0]  read_data;

  dsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsc_datapath #(
    .RING_LINES (RING_LINES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_tuser),
    .in_segments      (in_tdata[7:0]),
    .in_interval_us   (in_tdata[23:8]),
    .in_read_line     (in_tdata[27:24]),
    .in_read_pos      (in_tdata[31:28]),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_kind         (out_tuser),
    .out_line_slot    (line_slot),
    .out_exec_flag    (exec_flag),
    .out_blank_cycles (blank_cycles),
    .out_read_data    (read_data)
  );

  // pack result beat, padded to whole bytes
  assign out_tdata = {3'b000, read_data, blank_cycles, exec_flag, line_slot};

endmodule
